### hdl/ttm_pkg.sv
`timescale 1ns / 1ps

package ttm_pkg;

    localparam int NUM_CH      = 3;
    localparam int DIV_STEPS   = 48;
    localparam int NORM_STEPS  = 5;
    localparam int SQ_STEPS    = 20;
    localparam int CUBIC_STGS  = 10;
    // input reg + divider + filter + normalizer + squarings + ln product + x + cubic
    localparam int LANE_LAT    = 1 + DIV_STEPS + 1 + NORM_STEPS + SQ_STEPS + 1 + 1 + CUBIC_STGS;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // configuration register indexes
    localparam logic [2:0] REG_FAULT_LEVEL = 3'd0;
    localparam logic [2:0] REG_BALLAST     = 3'd1;
    localparam logic [2:0] REG_COEF_A      = 3'd2;
    localparam logic [2:0] REG_COEF_B      = 3'd3;
    localparam logic [2:0] REG_COEF_C      = 3'd4;
    localparam logic [2:0] REG_COEF_D      = 3'd5;
    localparam logic [2:0] REG_HIGH_LIMIT  = 3'd6;
    localparam logic [2:0] REG_LOW_LIMIT   = 3'd7;

    typedef struct packed {
        logic [11:0] sample_0;
        logic [11:0] sample_1;
        logic [11:0] sample_2;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temp_0;
        logic signed [15:0] temp_1;
        logic signed [15:0] temp_2;
        logic [2:0]         open_mask;
        logic [1:0]         hot_channel;
        logic               hot_alarm;
        logic [1:0]         cold_channel;
        logic               cold_alarm;
    } t_out;

    typedef struct packed {
        logic [11:0]        fault_level;
        logic [19:0]        ballast_ohms;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
    } t_cfg;

    // horner accumulator held to [-2^40, 2^40-1]
    function automatic logic signed [40:0] clamp_t(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< 40;
        if (v < -lim)
            return -41'sd1 <<< 40;
        else if (v > lim - 64'sd1)
            return 41'((lim - 64'sd1));
        else
            return 41'(v);
    endfunction

    function automatic logic signed [15:0] sat_q88(input logic signed [33:0] v);
        if (v > 34'sd32767)
            return 16'sh7fff;
        else if (v < -34'sd32768)
            return 16'sh8000;
        else
            return 16'(v);
    endfunction

    // elaboration-time ln in q16 of a q16 value, same steps as the lane hardware
    function automatic logic [20:0] ln_q16_const(input longint unsigned v);
        longint unsigned vv;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned l2;
        int unsigned     p;
        vv = (v < 64'd65536) ? 64'd65536 : v;
        p = 0;
        for (int i = 0; i < 63; i++) begin
            if ((vv >> (i + 1)) != 0)
                p = i + 1;
        end
        m = (p > 30) ? (vv >> (p - 30)) : (vv << (30 - p));
        frac = 0;
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        l2 = (longint'(p - 16) << 20) | frac;
        return 21'((l2 * 64'(LN2_Q30) + (64'd1 << 33)) >> 34);
    endfunction

endpackage

### hdl/thermistor_temperature_monitor.sv
`timescale 1ns / 1ps
// channel   direction  handshake                     beat
// command   in         start high, busy low          i_in: three 12-bit adc samples
// result    out        o_valid strobe, one cycle     o_out: temps, open mask, hot/cold
// config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// fully pipelined: a command beat is taken every cycle, busy never rises
// a result passes every lane stage and the merge register after its command beat
// latency is set by the 48-step divider and the 20 log2 squarings in each lane
// synchronous active-low reset clears the pipeline valid bits and config registers
// the receiver cannot stall: results are strobed for one cycle and not held

module thermistor_temperature_monitor #(
    parameter int unsigned FILTER_OHMS  = 0,
    parameter int unsigned NOMINAL_OHMS = 10000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ttm_pkg::t_in   i_in,
    output logic           o_valid,
    output ttm_pkg::t_out  o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import ttm_pkg::*;

    // config registers
    t_cfg               r_cfg;
    logic signed [15:0] r_high_limit;
    logic signed [15:0] r_low_limit;

    // one valid bit per pipeline stage, the merge stage is the last
    logic [LANE_LAT:0]  r_vld;

    logic [11:0]              w_samp [0:NUM_CH-1];
    logic signed [2:0][15:0]  w_temp;
    logic [2:0]               w_open;
    logic                     w_accept;
    logic                     w_cfg_wr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_level  <= 12'd0;
            r_cfg.ballast_ohms <= 20'd10000;
            r_cfg.coef_a       <= '0;
            r_cfg.coef_b       <= '0;
            r_cfg.coef_c       <= '0;
            r_cfg.coef_d       <= '0;
            r_high_limit       <= 16'sd15360;
            r_low_limit        <= 16'sd0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                REG_FAULT_LEVEL: r_cfg.fault_level  <= i_cfg_data[11:0];
                REG_BALLAST:     r_cfg.ballast_ohms <= i_cfg_data[19:0];
                REG_COEF_A:      r_cfg.coef_a       <= i_cfg_data;
                REG_COEF_B:      r_cfg.coef_b       <= i_cfg_data;
                REG_COEF_C:      r_cfg.coef_c       <= i_cfg_data;
                REG_COEF_D:      r_cfg.coef_d       <= i_cfg_data;
                REG_HIGH_LIMIT:  r_high_limit       <= i_cfg_data[15:0];
                REG_LOW_LIMIT:   r_low_limit        <= i_cfg_data[15:0];
                default:         r_low_limit        <= r_low_limit;
            endcase
        end
    end

    // lanes advance every cycle, so a plain shift tracks which stages hold a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else
            r_vld <= {r_vld[LANE_LAT-1:0], w_accept};
    end

    assign w_samp[0] = i_in.sample_0;
    assign w_samp[1] = i_in.sample_1;
    assign w_samp[2] = i_in.sample_2;

    // one lane per thermistor channel: divide, log, cubic
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        ttm_lane #(
            .FILTER_OHMS  (FILTER_OHMS),
            .NOMINAL_OHMS (NOMINAL_OHMS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_cfg    (r_cfg),
            .i_sample (w_samp[c]),
            .o_temp   (w_temp[c]),
            .o_open   (w_open[c])
        );
    end

    // hottest/coldest search and alarms, registered onto the result port
    ttm_merge u_merge (
        .i_clk        (i_clk),
        .i_temp       (w_temp),
        .i_open       (w_open),
        .i_high_limit (r_high_limit),
        .i_low_limit  (r_low_limit),
        .o_res        (o_out)
    );

    assign o_valid = r_vld[LANE_LAT];

endmodule

### hdl/ttm_lane.sv
`timescale 1ns / 1ps

module ttm_lane #(
    parameter int unsigned FILTER_OHMS  = 0,
    parameter int unsigned NOMINAL_OHMS = 10000
) (
    input  logic               i_clk,
    input  ttm_pkg::t_cfg      i_cfg,
    input  logic [11:0]        i_sample,
    output logic signed [15:0] o_temp,
    output logic               o_open
);
    import ttm_pkg::*;

    localparam logic [47:0] FILT    = 48'(FILTER_OHMS) << 16;
    localparam logic [47:0] R_FLOOR = FILT + 48'd65536;
    localparam logic [20:0] LN_NOM  = ln_q16_const(64'(NOMINAL_OHMS) << 16);

    logic               r_open [0:LANE_LAT-1];

    // divider
    logic [11:0]        r_dv_rem [0:DIV_STEPS-1];
    logic [11:0]        r_dv_s   [0:DIV_STEPS-1];
    logic [47:0]        r_dv_w   [0:DIV_STEPS];
    logic [32:0]        w_prod;

    // normalizer
    logic [47:0]        r_nm_v [0:NORM_STEPS];
    logic [4:0]         r_nm_c [0:NORM_STEPS];

    // log2 fraction by squaring
    logic [31:0]        r_sq [1:SQ_STEPS];
    logic [19:0]        r_fr [1:SQ_STEPS];
    logic [4:0]         r_ex [1:SQ_STEPS];

    logic [54:0]        r_l_prod;
    logic [55:0]        w_l_rnd;
    logic signed [22:0] r_x;
    logic signed [22:0] r_xd [1:6];

    // cubic
    logic signed [54:0] r_c1_p;
    logic signed [40:0] r_c2_t, r_c3_t, r_c5_t, r_c6_t, r_c8_t, r_c9_t;
    logic signed [43:0] r_c4_pl, r_c4_ph, r_c7_pl, r_c7_ph;
    logic signed [63:0] w_c5_sum, w_c8_sum;
    logic signed [41:0] w_rnd;
    logic signed [15:0] r_temp;

    assign w_prod = {13'd0, i_cfg.ballast_ohms} * {20'd0, 13'd4096 - {1'b0, i_sample}};

    always_ff @(posedge i_clk) begin
        r_open[0]   <= (i_sample <= i_cfg.fault_level);
        r_dv_rem[0] <= '0;
        r_dv_s[0]   <= i_sample;
        r_dv_w[0]   <= {w_prod[31:0], 16'd0};
        for (int i = 1; i < LANE_LAT; i++)
            r_open[i] <= r_open[i-1];
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [12:0] w_t;
        logic        w_ge;
        assign w_t  = {r_dv_rem[k], r_dv_w[k][47]};
        assign w_ge = (w_t >= {1'b0, r_dv_s[k]});
        always_ff @(posedge i_clk) begin
            r_dv_w[k+1] <= {r_dv_w[k][46:0], w_ge};
        end
        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_dv_rem[k+1] <= w_ge ? 12'(w_t - {1'b0, r_dv_s[k]}) : w_t[11:0];
                r_dv_s[k+1]   <= r_dv_s[k];
            end
        end
    end

    // filter subtraction with a one ohm floor
    always_ff @(posedge i_clk) begin
        r_nm_v[0] <= (r_dv_w[DIV_STEPS] > R_FLOOR) ? r_dv_w[DIV_STEPS] - FILT : 48'd65536;
        r_nm_c[0] <= '0;
    end

    // leading one to bit 47, shifts of 16, 8, 4, 2, 1
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 16 >> j;
        always_ff @(posedge i_clk) begin
            if (r_nm_v[j][47 -: SH] == '0) begin
                r_nm_v[j+1] <= r_nm_v[j] << SH;
                r_nm_c[j+1] <= r_nm_c[j] + 5'(SH);
            end else begin
                r_nm_v[j+1] <= r_nm_v[j];
                r_nm_c[j+1] <= r_nm_c[j];
            end
        end
    end

    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sq
        logic [30:0] w_m;
        logic [61:0] w_p;
        if (j == 1) begin : g_first
            assign w_m = r_nm_v[NORM_STEPS][47:17];
            always_ff @(posedge i_clk) begin
                r_fr[j] <= '0;
                r_ex[j] <= ~r_nm_c[NORM_STEPS];
            end
        end else begin : g_next
            assign w_m = r_sq[j-1][31] ? r_sq[j-1][31:1] : r_sq[j-1][30:0];
            always_ff @(posedge i_clk) begin
                r_fr[j] <= {r_fr[j-1][18:0], r_sq[j-1][31]};
                r_ex[j] <= r_ex[j-1];
            end
        end
        assign w_p = {31'd0, w_m} * {31'd0, w_m};
        always_ff @(posedge i_clk) begin
            r_sq[j] <= w_p[61:30];
        end
    end

    assign w_l_rnd = {1'b0, r_l_prod} + (56'd1 << 33);

    always_ff @(posedge i_clk) begin
        r_l_prod <= {r_ex[SQ_STEPS], r_fr[SQ_STEPS][18:0], r_sq[SQ_STEPS][31]} * LN2_Q30;
        r_x      <= $signed({2'b00, w_l_rnd[54:34]}) - $signed({2'b00, LN_NOM});
        r_xd[1]  <= r_x;
        for (int i = 2; i <= 6; i++)
            r_xd[i] <= r_xd[i-1];
    end

    assign w_c5_sum = (64'(r_c4_ph) <<< 20) + 64'(r_c4_pl);
    assign w_c8_sum = (64'(r_c7_ph) <<< 20) + 64'(r_c7_pl);
    assign w_rnd    = 42'(r_c9_t) + 42'sd128;

    // horner: ((d*x + c)*x + b)*x + a, wide products split at bit 20
    always_ff @(posedge i_clk) begin
        r_c1_p  <= 55'(i_cfg.coef_d) * 55'(r_x);
        r_c2_t  <= clamp_t(64'(r_c1_p >>> 16));
        r_c3_t  <= clamp_t(64'(r_c2_t) + 64'(i_cfg.coef_c));
        r_c4_pl <= 44'($signed({1'b0, r_c3_t[19:0]})) * 44'(r_xd[3]);
        r_c4_ph <= 44'($signed(r_c3_t[40:20])) * 44'(r_xd[3]);
        r_c5_t  <= clamp_t(w_c5_sum >>> 16);
        r_c6_t  <= clamp_t(64'(r_c5_t) + 64'(i_cfg.coef_b));
        r_c7_pl <= 44'($signed({1'b0, r_c6_t[19:0]})) * 44'(r_xd[6]);
        r_c7_ph <= 44'($signed(r_c6_t[40:20])) * 44'(r_xd[6]);
        r_c8_t  <= clamp_t(w_c8_sum >>> 16);
        r_c9_t  <= clamp_t(64'(r_c8_t) + 64'(i_cfg.coef_a));
        r_temp  <= r_open[LANE_LAT-2] ? 16'sd0 : sat_q88(34'(w_rnd >>> 8));
    end

    assign o_temp = r_temp;
    assign o_open = r_open[LANE_LAT-1];

endmodule

### hdl/ttm_merge.sv
`timescale 1ns / 1ps

module ttm_merge (
    input  logic                      i_clk,
    input  logic signed [2:0][15:0]   i_temp,
    input  logic [2:0]                i_open,
    input  logic signed [15:0]        i_high_limit,
    input  logic signed [15:0]        i_low_limit,
    output ttm_pkg::t_out             o_res
);
    import ttm_pkg::*;

    logic [1:0] w_hi, w_lo;
    logic       w_any;
    t_out       r_res;

    // first valid channel seeds the search, later ones win only strictly
    always_comb begin
        w_hi  = '0;
        w_lo  = '0;
        w_any = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (!i_open[i]) begin
                if (!w_any) begin
                    w_hi  = 2'(i);
                    w_lo  = 2'(i);
                    w_any = 1'b1;
                end else begin
                    if ($signed(i_temp[i]) > $signed(i_temp[w_hi]))
                        w_hi = 2'(i);
                    if ($signed(i_temp[i]) < $signed(i_temp[w_lo]))
                        w_lo = 2'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.temp_0       <= i_temp[0];
        r_res.temp_1       <= i_temp[1];
        r_res.temp_2       <= i_temp[2];
        r_res.open_mask    <= i_open;
        r_res.hot_channel  <= w_hi;
        r_res.cold_channel <= w_lo;
        r_res.hot_alarm    <= w_any && ($signed(i_temp[w_hi]) >= i_high_limit);
        r_res.cold_alarm   <= w_any && ($signed(i_temp[w_lo]) <= i_low_limit);
    end

    assign o_res = r_res;

endmodule

### sim/ttm_checker.sv
`timescale 1ns / 1ps

module ttm_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ttm_pkg::t_in   i_in,
    input  logic           i_valid,
    input  ttm_pkg::t_out  i_out,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending
);
    import ttm_pkg::*;

    localparam longint unsigned NOMINAL = 10000;

    logic [11:0]        fault_level;
    logic [19:0]        ballast;
    logic signed [31:0] ca, cb, cc, cd;
    logic signed [15:0] high_limit, low_limit;

    t_out expected_results[$];
    int   errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint hold_acc(longint v);
        longint lim;
        lim = 64'sd1 <<< 40;
        if (v < -lim) return -lim;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic longint natural_log_q16(longint unsigned v);
        longint unsigned m, frac, l2;
        int p;
        if (v < 65536) v = 65536;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
        frac = 0;
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l2 = (longint'(p - 16) << 20) | frac;
        return longint'((l2 * 64'd744261118 + (64'd1 << 33)) >> 34);
    endfunction

    function automatic longint channel_temp(logic [11:0] sample, longint ln_nom);
        longint unsigned s, q;
        longint x, t;
        s = (sample == 0) ? 1 : sample;
        q = ((longint'(ballast) * (4096 - s)) << 16) / s;
        if (q <= 65536) q = 65536;
        x = natural_log_q16(q) - ln_nom;
        t = hold_acc(floor_shift(longint'(cd) * x, 16));
        t = hold_acc(t + longint'(cc));
        t = hold_acc(floor_shift(t * x, 16));
        t = hold_acc(t + longint'(cb));
        t = hold_acc(floor_shift(t * x, 16));
        t = hold_acc(t + longint'(ca));
        t = floor_shift(t + 128, 8);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t;
    endfunction

    function automatic t_out predict_readings(t_in beat);
        t_out r;
        logic [11:0] s[3];
        longint tv[3];
        longint ln_nom;
        int hi, lo;
        bit any;
        s[0] = beat.sample_0;
        s[1] = beat.sample_1;
        s[2] = beat.sample_2;
        ln_nom = natural_log_q16(NOMINAL << 16);
        hi = 0;
        lo = 0;
        any = 0;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            tv[i] = 0;
            if (s[i] <= fault_level) begin
                r.open_mask[i] = 1'b1;
            end else begin
                tv[i] = channel_temp(s[i], ln_nom);
                if (!any) begin
                    hi = i;
                    lo = i;
                    any = 1;
                end else begin
                    if (tv[i] > tv[hi]) hi = i;
                    if (tv[i] < tv[lo]) lo = i;
                end
            end
        end
        r.temp_0 = 16'(tv[0]);
        r.temp_1 = 16'(tv[1]);
        r.temp_2 = 16'(tv[2]);
        r.hot_channel  = any ? 2'(hi) : 2'd0;
        r.cold_channel = any ? 2'(lo) : 2'd0;
        r.hot_alarm  = any && (tv[hi] >= longint'(high_limit));
        r.cold_alarm = any && (tv[lo] <= longint'(low_limit));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fault_level <= '0;
            ballast     <= 20'd10000;
            ca <= '0;
            cb <= '0;
            cc <= '0;
            cd <= '0;
            high_limit <= 16'sd15360;
            low_limit  <= '0;
            errors = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out);
                    errors++;
                end else begin
                    t_out e;
                    e = expected_results.pop_front();
                    if (e !== i_out) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, i_out);
                        errors++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_readings(i_in));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FAULT_LEVEL: fault_level <= i_cfg_data[11:0];
                    REG_BALLAST:     ballast <= i_cfg_data[19:0];
                    REG_COEF_A:      ca <= i_cfg_data;
                    REG_COEF_B:      cb <= i_cfg_data;
                    REG_COEF_C:      cc <= i_cfg_data;
                    REG_COEF_D:      cd <= i_cfg_data;
                    REG_HIGH_LIMIT:  high_limit <= i_cfg_data[15:0];
                    REG_LOW_LIMIT:   low_limit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### sim/tb_thermistor_temperature_monitor.sv
`timescale 1ns / 1ps

module tb_thermistor_temperature_monitor;
    import ttm_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           i_in;
    logic          o_valid;
    t_out          o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;
    int            errors;
    int            pending;
    int            quiet_cycles;
    int            idle_pct;

    thermistor_temperature_monitor dut (.*);

    ttm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in(i_in), .i_valid(o_valid), .i_out(o_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any accepted beat, result beat or reset clears the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one register write, held until the ready side takes it
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one command beat, with optional idle cycles ahead of it
    task automatic send_samples(logic [11:0] s0, logic [11:0] s1, logic [11:0] s2);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= '{sample_0: s0, sample_1: s1, sample_2: s2};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // block is idle once every result is back plus the pipeline depth
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LANE_LAT + 4) @(negedge i_clk);
    endtask

    function automatic logic [11:0] rand_sample();
        case ($urandom_range(5))
            0: return 12'($urandom_range(15));
            1: return 12'(4095 - $urandom_range(15));
            default: return 12'($urandom);
        endcase
    endfunction

    // typical ntc-like coefficients mixed with wild ones
    task automatic random_setting(bit extreme);
        if (extreme) begin
            write_reg(REG_COEF_A, $urandom);
            write_reg(REG_COEF_B, $urandom);
            write_reg(REG_COEF_C, $urandom);
            write_reg(REG_COEF_D, $urandom);
            write_reg(REG_BALLAST, $urandom_range(1) ? 32'hfffff : 32'd1);
            write_reg(REG_FAULT_LEVEL, $urandom_range(1) ? 32'hfff : 32'd0);
        end else begin
            write_reg(REG_COEF_A, 32'($signed(25 << 16) + $signed($urandom_range(65535)) - 32768));
            write_reg(REG_COEF_B, 32'(-$signed($urandom_range(30 << 16))));
            write_reg(REG_COEF_C, 32'($signed($urandom_range(1 << 16)) - 32768));
            write_reg(REG_COEF_D, 32'($signed($urandom_range(4096)) - 2048));
            write_reg(REG_BALLAST, $urandom_range(1000, 100000));
            write_reg(REG_FAULT_LEVEL, $urandom_range(200));
        end
        write_reg(REG_HIGH_LIMIT, $urandom_range(1) ? $urandom : 32'($urandom_range(20000)));
        write_reg(REG_LOW_LIMIT, $urandom_range(1) ? $urandom : 32'($urandom_range(8000)));
    endtask

    initial begin
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_FAULT_LEVEL;
        i_cfg_data  = '0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset setting, then extremes and ties
        send_samples(12'd0, 12'd4095, 12'd2048);
        send_samples(12'd1, 12'd1, 12'd1);
        drain();
        write_reg(REG_COEF_A, 32'sd25 << 16);
        write_reg(REG_COEF_B, -(32'sd22 << 16));
        write_reg(REG_COEF_C, 32'sd1 << 16);
        write_reg(REG_COEF_D, -32'sd4000);
        write_reg(REG_FAULT_LEVEL, 32'd100);
        write_reg(REG_BALLAST, 32'd10000);
        write_reg(REG_HIGH_LIMIT, 32'd40 << 8);
        write_reg(REG_LOW_LIMIT, 32'd5 << 8);
        send_samples(12'd100, 12'd100, 12'd100);   // all open
        send_samples(12'd101, 12'd4095, 12'd2048);
        send_samples(12'd2048, 12'd2048, 12'd2048); // ties pick lowest index
        send_samples(12'd4095, 12'd101, 12'd100);
        send_samples(12'd3000, 12'd1000, 12'd2048);
        drain();
        write_reg(REG_BALLAST, 32'd0);              // zero ballast clamps R to one ohm
        write_reg(REG_COEF_A, 32'h7fffffff);
        write_reg(REG_COEF_D, 32'h80000000);
        write_reg(REG_FAULT_LEVEL, 32'd0);
        write_reg(REG_HIGH_LIMIT, 32'h8000);
        write_reg(REG_LOW_LIMIT, 32'h7fff);
        send_samples(12'd0, 12'd1, 12'd4095);
        drain();
        write_reg(REG_BALLAST, 32'hfffff);
        send_samples(12'd1, 12'd4095, 12'd2);
        drain();
        write_reg(REG_FAULT_LEVEL, 32'hfff);
        send_samples(12'd4095, 12'd4095, 12'd0);   // fault level at top: all open
        drain();

        // random phases: sender idles rarely, then often, then never
        for (int phase = 0; phase < 12; phase++) begin
            idle_pct = (phase < 4) ? 9 : (phase < 8) ? 88 : 0;
            random_setting(phase % 3 == 2);
            repeat (140) send_samples(rand_sample(), rand_sample(), rand_sample());
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
